### sv/deq_pkg.sv
// ----------------------------------------------------------------------------
// deq_pkg
// Shared sizes, types and codes for the double-ended queue.
// ----------------------------------------------------------------------------
package deq_pkg;

    localparam int DEPTH  = 16;
    localparam int WORD_W = 32;
    localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int OCC_W  = 5;

    typedef logic [PTR_W-1:0]  ptr_t;
    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [CNT_W:0]    sum_t;
    typedef logic [OCC_W-1:0]  occ_t;
    typedef logic [1:0]        cmd_t;
    typedef logic [1:0]        status_t;

    localparam cmd_t CMD_PUSH_FRONT = 2'd0;
    localparam cmd_t CMD_PUSH_REAR  = 2'd1;
    localparam cmd_t CMD_POP_FRONT  = 2'd2;
    localparam cmd_t CMD_POP_REAR   = 2'd3;

    localparam status_t ST_DONE  = 2'd0;
    localparam status_t ST_EMPTY = 2'd1;
    localparam status_t ST_FULL  = 2'd2;

    typedef enum logic {
        S_IDLE,
        S_READ
    } state_t;

    // result control handed from the sequencer to the output register
    typedef struct packed {
        logic    load;
        logic    take_ram;
        status_t status;
        occ_t    occupancy;
    } res_ctl_t;

    // occupancy field shows the count modulo 32
    function automatic occ_t occ_of(input cnt_t c);
        logic [CNT_W+OCC_W-1:0] w;
        w = {{OCC_W{1'b0}}, c};
        return w[OCC_W-1:0];
    endfunction

endpackage

### sv/deq_ram.sv
// ----------------------------------------------------------------------------
// deq_ram
// Single-port-write, single-port-read synchronous RAM, registered read data.
// ----------------------------------------------------------------------------
module deq_ram #(
    parameter int WORDS  = 16,
    parameter int ADDR_W = 4,
    parameter int DATA_W = 32
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [WORDS];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### sv/deq_ctrl.sv
// ----------------------------------------------------------------------------
// deq_ctrl
// Ring pointer, entry count and request sequencer of the queue.
// ----------------------------------------------------------------------------
module deq_ctrl (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  deq_pkg::cmd_t            cmd,
    input  logic                     out_free,
    output logic                     wr_en,
    output deq_pkg::ptr_t            wr_addr,
    output logic                     rd_en,
    output deq_pkg::ptr_t            rd_addr,
    output deq_pkg::res_ctl_t        res
);

    import deq_pkg::*;

    localparam ptr_t PTR_LAST = ptr_t'(DEPTH - 1);
    localparam cnt_t CNT_FULL = cnt_t'(DEPTH);
    localparam sum_t SUM_WRAP = sum_t'(DEPTH);

    state_t state_reg, state_next;
    ptr_t   front_reg, front_next;
    cnt_t   count_reg, count_next;

    logic   accept, is_push, full, empty;
    ptr_t   front_inc, front_dec, rear_pos, last_pos;
    sum_t   rear_sum, rear_wrap;

    assign accept  = in_valid && in_ready;
    assign is_push = (cmd == CMD_PUSH_FRONT) || (cmd == CMD_PUSH_REAR);
    assign full    = (count_reg == CNT_FULL);
    assign empty   = (count_reg == '0);

    // ring neighbors of the front and the rear, wrap without a divider
    assign front_inc = (front_reg == PTR_LAST) ? '0 : front_reg + ptr_t'(1);
    assign front_dec = (front_reg == '0) ? PTR_LAST : front_reg - ptr_t'(1);
    assign rear_sum  = sum_t'(front_reg) + sum_t'(count_reg);
    assign rear_wrap = (rear_sum >= SUM_WRAP) ? rear_sum - SUM_WRAP : rear_sum;
    assign rear_pos  = rear_wrap[PTR_W-1:0];
    assign last_pos  = (rear_pos == '0) ? PTR_LAST : rear_pos - ptr_t'(1);

    always_comb
    begin
        wr_en   = accept && is_push && !full;
        wr_addr = (cmd == CMD_PUSH_FRONT) ? front_dec : rear_pos;
        rd_en   = accept && !is_push && !empty;
        rd_addr = (cmd == CMD_POP_FRONT) ? front_reg : last_pos;
    end

    always_comb
    begin
        front_next = front_reg;
        count_next = count_reg;
        if (wr_en)
        begin
            count_next = count_reg + cnt_t'(1);
            if (cmd == CMD_PUSH_FRONT)
            begin
                front_next = front_dec;
            end
        end
        else if (rd_en)
        begin
            count_next = count_reg - cnt_t'(1);
            if (cmd == CMD_POP_FRONT)
            begin
                front_next = front_inc;
            end
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (rd_en)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready      = 1'b0;
        res.load      = 1'b0;
        res.take_ram  = 1'b0;
        res.status    = ST_DONE;
        res.occupancy = occ_of(count_next);
        case (state_reg)
            S_IDLE:
            begin
                in_ready = out_free;
                // pushes and failed pops finish in the accept cycle
                res.load = accept && !rd_en;
                if (accept && is_push && full)
                begin
                    res.status = ST_FULL;
                end
                else if (accept && !is_push && empty)
                begin
                    res.status = ST_EMPTY;
                end
            end
            S_READ:
            begin
                res.load      = 1'b1;
                res.take_ram  = 1'b1;
                res.occupancy = occ_of(count_reg);
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            front_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            front_reg <= front_next;
            count_reg <= count_next;
        end
    end

endmodule

### sv/double_ended_queue.sv
// ----------------------------------------------------------------------------
// double_ended_queue
// Bounded deque of signed words kept in a ring inside one synchronous RAM.
// ----------------------------------------------------------------------------
// Each request beat pushes a word at the front or rear, or pops one from the
// front or rear, and returns exactly one result beat with the popped word, a
// status (done, empty on pop, full on push) and the entry count after the
// request. A push or a refused request loads its result in the accept cycle; a
// successful pop passes through S_READ first, since the entry RAM's read data is
// registered. in_ready is low during the pop read cycle and while a result beat
// waits unaccepted with out_ready low. The RAM has no reset; entries are only
// read after a push wrote them.
module double_ended_queue (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  deq_pkg::cmd_t                 cmd,
    input  logic signed [deq_pkg::WORD_W-1:0] push_value,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [deq_pkg::WORD_W-1:0] pop_value,
    output deq_pkg::status_t              status,
    output deq_pkg::occ_t                 occupancy
);

    import deq_pkg::*;

    logic              out_valid_reg;
    logic [WORD_W-1:0] pop_value_reg;
    status_t           status_reg;
    occ_t              occupancy_reg;

    logic              out_free;
    logic              wr_en, rd_en;
    ptr_t              wr_addr, rd_addr;
    logic [WORD_W-1:0] rd_data;
    res_ctl_t          res;

    assign out_free = !out_valid_reg || out_ready;

    deq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .cmd      (cmd),
        .out_free (out_free),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .res      (res)
    );

    deq_ram #(
        .WORDS  (DEPTH),
        .ADDR_W (PTR_W),
        .DATA_W (WORD_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (push_value),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // result beat register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res.load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res.load)
        begin
            pop_value_reg <= res.take_ram ? rd_data : '0;
            status_reg    <= res.status;
            occupancy_reg <= res.occupancy;
        end
    end

    assign out_valid = out_valid_reg;
    assign pop_value = pop_value_reg;
    assign status    = status_reg;
    assign occupancy = occupancy_reg;

endmodule

### sv/deq_checker.sv
// ----------------------------------------------------------------------------
// deq_checker
// Port-level checks of the double-ended queue, bound to the top level.
// ----------------------------------------------------------------------------
module deq_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              out_valid,
    input logic                              out_ready,
    input logic signed [deq_pkg::WORD_W-1:0] pop_value,
    input deq_pkg::status_t                  status,
    input deq_pkg::occ_t                     occupancy
);

    import deq_pkg::*;

    // a stalled result beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(pop_value)
            && $stable(status) && $stable(occupancy))
    else $error("result beat changed while stalled");

    // refused requests carry no word
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_EMPTY || status == ST_FULL) |-> pop_value == '0)
    else $error("refused request returned a word");

    // full is only reported at capacity
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_FULL |-> occupancy == occ_t'(DEPTH))
    else $error("full reported below capacity");

    // empty is only reported with nothing held
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_EMPTY |-> occupancy == '0)
    else $error("empty reported with entries held");

    // count never exceeds the capacity
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (DEPTH > 31) || (occupancy <= occ_t'(DEPTH)))
    else $error("occupancy above capacity");

endmodule

bind double_ended_queue deq_checker u_deq_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .pop_value (pop_value),
    .status    (status),
    .occupancy (occupancy)
);

### tb/double_ended_queue_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_queue_tb
// Self-checking bench for the bounded double-ended queue.
// ----------------------------------------------------------------------------
// A short table of directed requests covers empty pops, extreme words and the
// full refusal. A long run of random bursts follows; some bursts lean toward
// pushes and some toward pops, so that the ring keeps wrapping and keeps
// reaching both full and empty. A local ring model predicts every result beat.
// Both sides insert random idle cycles.
module double_ended_queue_tb;

    import deq_pkg::*;

    localparam int HALF_PERIOD    = 4;
    localparam int RANDOM_ITEMS   = 850;
    localparam int WATCHDOG_LIMIT = 200;
    localparam int NUM_ROWS       = 12;

    typedef logic signed [WORD_W-1:0] word_t;

    typedef struct packed {
        word_t   pop_value;
        status_t status;
        occ_t    occupancy;
    } deq_result_t;

    // directed row; a row with more than one repeat draws a fresh word each time
    typedef struct packed {
        cmd_t        cmd;
        word_t       value;
        logic [7:0]  reps;
        logic        typed;
        deq_result_t want;
    } deq_row_t;

    logic  clk        = 1'b0;
    logic  rst_n      = 1'b0;
    logic  in_valid   = 1'b0;
    logic  in_ready;
    cmd_t  cmd        = CMD_PUSH_FRONT;
    word_t push_value = '0;
    logic  out_valid;
    logic  out_ready  = 1'b0;
    word_t pop_value;
    status_t status;
    occ_t    occupancy;

    // ring model of the queue
    word_t       ring_words [DEPTH];
    int          ring_front = 0;
    int          ring_count = 0;

    deq_result_t pending_results [$];
    deq_row_t    dir_rows [NUM_ROWS];

    int n_errors   = 0;
    int n_requests = 0;
    int n_results  = 0;
    int n_full     = 0;
    int n_empty    = 0;
    int idle_cycles = 0;

    double_ended_queue i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .cmd        (cmd),
        .push_value (push_value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .pop_value  (pop_value),
        .status     (status),
        .occupancy  (occupancy)
    );

    always #HALF_PERIOD clk = ~clk;

    function automatic deq_result_t deque_predict(input cmd_t req_cmd, input word_t word);
        deq_result_t r;
        r.pop_value = '0;
        r.status    = ST_DONE;
        if (req_cmd == CMD_PUSH_FRONT || req_cmd == CMD_PUSH_REAR) begin
            if (ring_count >= DEPTH) begin
                r.status = ST_FULL;
                n_full++;
            end
            else if (req_cmd == CMD_PUSH_FRONT) begin
                ring_front = (ring_front + DEPTH - 1) % DEPTH;
                ring_words[ring_front] = word;
                ring_count++;
            end
            else begin
                ring_words[(ring_front + ring_count) % DEPTH] = word;
                ring_count++;
            end
        end
        else begin
            if (ring_count == 0) begin
                r.status = ST_EMPTY;
                n_empty++;
            end
            else if (req_cmd == CMD_POP_FRONT) begin
                r.pop_value = ring_words[ring_front];
                ring_front = (ring_front + 1) % DEPTH;
                ring_count--;
            end
            else begin
                r.pop_value = ring_words[(ring_front + ring_count - 1) % DEPTH];
                ring_count--;
            end
        end
        r.occupancy = occ_t'(ring_count);
        return r;
    endfunction

    function automatic word_t random_word();
        int pick;
        pick = $urandom_range(0, 9);
        case (pick)
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2:       return word_t'($urandom_range(0, 31)) - 16;
            default: return word_t'($urandom);
        endcase
    endfunction

    // hold the beat until accepted, then log its expected result
    task automatic send_request(input cmd_t req_cmd, input word_t word, input logic typed,
                                input deq_result_t want, input int gap);
        deq_result_t predicted;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        cmd        <= req_cmd;
        push_value <= word;
        do @(posedge clk); while (!in_ready);
        predicted = deque_predict(req_cmd, word);
        pending_results.push_back(typed ? want : predicted);
        n_requests++;
    endtask

    initial begin : stimulus
        deq_result_t no_want;
        deq_row_t    row;
        cmd_t        req_cmd;
        int          mode;
        int          burst;
        int          pick;
        int          n_random;
        logic        fast;
        logic        is_push;

        no_want = '0;
        dir_rows[0]  = {CMD_POP_FRONT,  32'h0000_0000, 8'd1, 1'b1, 32'h0, ST_EMPTY, 5'd0};
        dir_rows[1]  = {CMD_POP_REAR,   32'h1234_5678, 8'd1, 1'b1, 32'h0, ST_EMPTY, 5'd0};
        dir_rows[2]  = {CMD_PUSH_FRONT, 32'h7FFF_FFFF, 8'd1, 1'b1, 32'h0, ST_DONE,  5'd1};
        dir_rows[3]  = {CMD_PUSH_REAR,  32'h8000_0000, 8'd1, 1'b1, 32'h0, ST_DONE,  5'd2};
        dir_rows[4]  = {CMD_POP_FRONT,  32'hFFFF_FFFF, 8'd1, 1'b1, 32'h7FFF_FFFF, ST_DONE, 5'd1};
        dir_rows[5]  = {CMD_POP_REAR,   32'h0000_0000, 8'd1, 1'b1, 32'h8000_0000, ST_DONE, 5'd0};
        dir_rows[6]  = {CMD_PUSH_REAR,  32'h0000_0000, 8'd1, 1'b1, 32'h0, ST_DONE,  5'd1};
        dir_rows[7]  = {CMD_PUSH_FRONT, 32'hFFFF_FFFF, 8'd1, 1'b1, 32'h0, ST_DONE,  5'd2};
        dir_rows[8]  = {CMD_PUSH_FRONT, 32'h0, 8'(DEPTH / 2 - 1), 1'b0, no_want};
        dir_rows[9]  = {CMD_PUSH_REAR,  32'h0, 8'(DEPTH / 2 - 1), 1'b0, no_want};
        dir_rows[10] = {CMD_PUSH_REAR,  32'h5A5A_5A5A, 8'd1, 1'b1, 32'h0, ST_FULL,
                        occ_t'(DEPTH)};
        dir_rows[11] = {CMD_PUSH_FRONT, 32'hA5A5_A5A5, 8'd1, 1'b1, 32'h0, ST_FULL,
                        occ_t'(DEPTH)};

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < NUM_ROWS; i++) begin
            row = dir_rows[i];
            for (int r = 0; r < row.reps; r++) begin
                send_request(row.cmd, (row.reps > 1) ? random_word() : row.value,
                             row.typed, row.want, $urandom_range(0, 5));
            end
        end

        n_random = 0;
        while (n_random < RANDOM_ITEMS) begin
            mode  = $urandom_range(0, 3);
            burst = $urandom_range(1, 40);
            fast  = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < burst && n_random < RANDOM_ITEMS; k++) begin
                pick = $urandom_range(0, 99);
                case (mode)
                    0:       is_push = (pick < 85);
                    1:       is_push = (pick < 15);
                    default: is_push = (pick < 50);
                endcase
                if (is_push)
                    req_cmd = $urandom_range(0, 1) ? CMD_PUSH_REAR : CMD_PUSH_FRONT;
                else
                    req_cmd = $urandom_range(0, 1) ? CMD_POP_REAR : CMD_POP_FRONT;
                if (mode == 3)
                    req_cmd = cmd_t'($urandom_range(0, 3));
                send_request(req_cmd, random_word(), 1'b0, no_want,
                             fast ? 0 : $urandom_range(0, 5));
                n_random++;
                // hold the sender once until every result is back
                if (n_random == RANDOM_ITEMS / 2) begin
                    in_valid <= 1'b0;
                    while (pending_results.size() != 0) @(posedge clk);
                end
            end
        end

        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);

        $display("ran %0d requests and checked %0d result beats", n_requests, n_results);
        $display("refused pushes on a full ring: %0d, pops on an empty ring: %0d",
                 n_full, n_empty);
        if (n_errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // receiver: random stalls, with calm stretches where ready stays high
    initial begin : receiver
        int   stall;
        int   rx_left;
        logic rx_calm;
        rx_left = 0;
        rx_calm = 1'b0;
        @(posedge rst_n);
        forever begin
            if (rx_left == 0) begin
                rx_calm = ($urandom_range(0, 2) == 0);
                rx_left = $urandom_range(8, 40);
            end
            rx_left--;
            stall = rx_calm ? 0 : $urandom_range(0, 5);
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!(out_valid && out_ready));
        end
    end

    always @(posedge clk) begin : check_beat
        deq_result_t want;
        if (rst_n && out_valid && out_ready) begin
            n_results++;
            if (pending_results.size() == 0) begin
                $error("result beat with no request outstanding");
                n_errors++;
            end
            else begin
                want = pending_results.pop_front();
                if (pop_value !== want.pop_value) begin
                    $error("pop_value mismatch: expected %0d, actual %0d",
                           want.pop_value, pop_value);
                    n_errors++;
                end
                if (status !== want.status) begin
                    $error("status mismatch: expected %0d, actual %0d", want.status, status);
                    n_errors++;
                end
                if (occupancy !== want.occupancy) begin
                    $error("occupancy mismatch: expected %0d, actual %0d",
                           want.occupancy, occupancy);
                    n_errors++;
                end
            end
        end
    end

    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles = 0;
        else
            idle_cycles = idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("no beat moved for %0d cycles", WATCHDOG_LIMIT);
            $display("status: fail");
            $finish;
        end
    end

endmodule
